// ===== hw/rtl/avt_pkg.sv =====
// Shared types and constants for the attribute/value tuple tokenizer.
`default_nettype none
package avt_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 8;
  localparam int unsigned KindW  = 2;

  // Input queue between front and back.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QAw    = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Configuration register indexes.
  localparam logic CFG_ATTR_LIMIT  = 1'b0;
  localparam logic CFG_VALUE_LIMIT = 1'b1;

  localparam logic [CountW-1:0] ATTR_LIMIT_RST  = 8'd32;
  localparam logic [CountW-1:0] VALUE_LIMIT_RST = 8'd64;

  // Characters of interest.
  localparam logic [ByteW-1:0] CH_NL    = 8'd10;
  localparam logic [ByteW-1:0] CH_TAB   = 8'd9;
  localparam logic [ByteW-1:0] CH_CR    = 8'd13;
  localparam logic [ByteW-1:0] CH_SPACE = 8'd32;
  localparam logic [ByteW-1:0] CH_HASH  = 8'd35;
  localparam logic [ByteW-1:0] CH_EQ    = 8'd61;
  localparam logic [ByteW-1:0] CH_QUOTE = 8'd34;

  // Event kinds on the result channel.
  localparam logic [KindW-1:0] EV_SKIP  = 2'd0;
  localparam logic [KindW-1:0] EV_ATTR  = 2'd1;
  localparam logic [KindW-1:0] EV_VALUE = 2'd2;
  localparam logic [KindW-1:0] EV_END   = 2'd3;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_NL,
    CLS_SEP,
    CLS_HASH,
    CLS_EQ,
    CLS_QUOTE
  } char_cls_e;

  typedef struct packed {
    logic [ByteW-1:0] text_byte;
    char_cls_e        cls;
  } token_t;

  function automatic char_cls_e classify(input logic [ByteW-1:0] c);
    char_cls_e r;
    r = CLS_OTHER;
    if (c == CH_NL) begin
      r = CLS_NL;
    end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
      r = CLS_SEP;
    end else if (c == CH_HASH) begin
      r = CLS_HASH;
    end else if (c == CH_EQ) begin
      r = CLS_EQ;
    end else if (c == CH_QUOTE) begin
      r = CLS_QUOTE;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/avt_front.sv =====
// Front end: takes input items and tags each byte with its character class.
`default_nettype none
module avt_front
  import avt_pkg::*;
(
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] text_byte_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output token_t           q_tok_o
);

  assign in_ready_o = ~q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;

  always_comb begin
    q_tok_o.text_byte = text_byte_i;
    q_tok_o.cls       = classify(text_byte_i);
  end

endmodule
`default_nettype wire

// ===== hw/rtl/avt_queue.sv =====
// Short token queue between the classifying front and the parsing back.
`default_nettype none
module avt_queue
  import avt_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  token_t push_tok_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output token_t pop_tok_o
);

  token_t           mem_q [QDepth];
  logic [QAw-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == QCntW'(QDepth));
  assign valid_o   = (cnt_q != '0);
  assign pop_tok_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QAw'(QDepth - 1)) ? '0 : wr_ptr_q + QAw'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QAw'(QDepth - 1)) ? '0 : rd_ptr_q + QAw'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/avt_back.sv =====
// Back end: tuple parse state machine, truncation counters and result register.
`default_nettype none
module avt_back
  import avt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  input  logic              q_valid_i,
  input  token_t            q_tok_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ByteW-1:0]  out_char_o,
  output logic [KindW-1:0]  event_kind_o,
  output logic              tuple_begins_o,
  output logic              dropped_o
);

  localparam logic [2:0] PH_BETWEEN    = 3'd0;
  localparam logic [2:0] PH_ATTR       = 3'd1;
  localparam logic [2:0] PH_AFTER_ATTR = 3'd2;
  localparam logic [2:0] PH_AFTER_EQ   = 3'd3;
  localparam logic [2:0] PH_BARE       = 3'd4;
  localparam logic [2:0] PH_QUOTED     = 3'd5;
  localparam logic [2:0] PH_COMMENT    = 3'd6;

  logic [CountW-1:0] attr_limit_q, value_limit_q;
  logic [2:0]        phase_q, phase_d;
  logic [CountW-1:0] attr_cnt_q, attr_cnt_d, value_cnt_q, value_cnt_d;
  logic              oval_q;
  logic [ByteW-1:0]  ochar_q;
  logic [KindW-1:0]  okind_q, kind_d;
  logic              obeg_q, beg_d, odrop_q, drop_d;
  logic              take_attr, take_value, clr_cnt;
  logic              attr_room, value_room;

  assign q_pop_o    = q_valid_i & (~oval_q | out_ready_i);
  assign attr_room  = attr_cnt_q < attr_limit_q;
  assign value_room = value_cnt_q < value_limit_q;

  always_comb begin
    phase_d    = phase_q;
    kind_d     = EV_SKIP;
    beg_d      = 1'b0;
    take_attr  = 1'b0;
    take_value = 1'b0;
    clr_cnt    = 1'b0;
    if (q_tok_i.cls == CLS_NL) begin
      kind_d  = EV_END;
      phase_d = PH_BETWEEN;
      clr_cnt = 1'b1;
    end else begin
      case (phase_q)
        PH_ATTR: begin
          if (q_tok_i.cls == CLS_EQ) begin
            phase_d = PH_AFTER_EQ;
          end else if (q_tok_i.cls == CLS_SEP) begin
            phase_d = PH_AFTER_ATTR;
          end else begin
            kind_d    = EV_ATTR;
            take_attr = 1'b1;
          end
        end
        PH_AFTER_EQ: begin
          if (q_tok_i.cls == CLS_QUOTE) begin
            phase_d = PH_QUOTED;
          end else if (q_tok_i.cls != CLS_SEP) begin
            phase_d    = PH_BARE;
            kind_d     = EV_VALUE;
            take_value = 1'b1;
          end
        end
        PH_BARE: begin
          if (q_tok_i.cls == CLS_SEP) begin
            phase_d = PH_BETWEEN;
          end else begin
            kind_d     = EV_VALUE;
            take_value = 1'b1;
          end
        end
        PH_QUOTED: begin
          if (q_tok_i.cls == CLS_QUOTE) begin
            phase_d = PH_BETWEEN;
          end else begin
            kind_d     = EV_VALUE;
            take_value = 1'b1;
          end
        end
        PH_COMMENT: begin
          phase_d = PH_COMMENT;
        end
        default: begin
          // between tuples, after an attribute, or an unused code
          if (q_tok_i.cls == CLS_SEP) begin
            phase_d = phase_q;
          end else if (q_tok_i.cls == CLS_HASH) begin
            phase_d = PH_COMMENT;
          end else if (q_tok_i.cls == CLS_EQ && phase_q == PH_AFTER_ATTR) begin
            phase_d = PH_AFTER_EQ;
          end else begin
            beg_d   = 1'b1;
            clr_cnt = 1'b1;
            if (q_tok_i.cls == CLS_EQ) begin
              phase_d = PH_AFTER_EQ;
            end else begin
              phase_d   = PH_ATTR;
              kind_d    = EV_ATTR;
              take_attr = 1'b1;
            end
          end
        end
      endcase
    end
  end

  // A tuple opener clears the counts before its own first char is counted.
  always_comb begin
    attr_cnt_d  = attr_cnt_q;
    value_cnt_d = value_cnt_q;
    drop_d      = 1'b0;
    if (clr_cnt) begin
      attr_cnt_d  = '0;
      value_cnt_d = '0;
    end
    if (take_attr) begin
      if (clr_cnt ? (attr_limit_q != '0) : attr_room) begin
        attr_cnt_d = attr_cnt_d + CountW'(1);
      end else begin
        drop_d = 1'b1;
      end
    end
    if (take_value) begin
      if (value_room) begin
        value_cnt_d = value_cnt_q + CountW'(1);
      end else begin
        drop_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_limit_q  <= ATTR_LIMIT_RST;
      value_limit_q <= VALUE_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ATTR_LIMIT:  attr_limit_q  <= cfg_wdata_i;
        CFG_VALUE_LIMIT: value_limit_q <= cfg_wdata_i;
        default: begin
          attr_limit_q <= attr_limit_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_BETWEEN;
      attr_cnt_q  <= '0;
      value_cnt_q <= '0;
      oval_q      <= 1'b0;
    end else begin
      if (q_pop_o) begin
        phase_q     <= phase_d;
        attr_cnt_q  <= attr_cnt_d;
        value_cnt_q <= value_cnt_d;
        oval_q      <= 1'b1;
      end else if (out_ready_i) begin
        oval_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ochar_q <= q_tok_i.text_byte;
      okind_q <= kind_d;
      obeg_q  <= beg_d;
      odrop_q <= drop_d;
    end
  end

  assign out_valid_o    = oval_q;
  assign out_char_o     = ochar_q;
  assign event_kind_o   = okind_q;
  assign tuple_begins_o = obeg_q;
  assign dropped_o      = odrop_q;

endmodule
`default_nettype wire

// ===== hw/rtl/attr_value_tuple_tokenizer.sv =====
// Top level of the attribute/value tuple tokenizer.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------------------
//  input    | in_valid_i / in_ready_o   | text_byte_i[7:0]
//  result   | out_valid_o / out_ready_i | out_char_o, event_kind_o, tuple_begins_o,
//           |                           | dropped_o
//  config   | cfg_we_i (no wait)        | cfg_idx_i, cfg_wdata_i[7:0]
//
// One item in, one item out, one item per cycle sustained while out_ready_i stays
// high. A byte is held in the token queue and then in the result register.
// The parse state loop in the back end sets the rate.
// Reset clears the parse state, counts and queue, and loads the limits 32 / 64.
// A stalled result holds the back end; the two-entry queue keeps accepting
// until it fills, then drops in_ready_o.
`default_nettype none
module attr_value_tuple_tokenizer
  import avt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ByteW-1:0]  text_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ByteW-1:0]  out_char_o,
  output logic [KindW-1:0]  event_kind_o,
  output logic              tuple_begins_o,
  output logic              dropped_o
);

  logic   q_push, q_full, q_pop, q_valid;
  token_t push_tok, pop_tok;

  // Classify each incoming byte and push it into the queue.
  avt_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .text_byte_i (text_byte_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_tok_o     (push_tok)
  );

  // Decouple the front from result back-pressure.
  avt_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_tok_i (push_tok),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_tok_o  (pop_tok)
  );

  // Advance the tuple parser and register the event.
  avt_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .q_valid_i      (q_valid),
    .q_tok_i        (pop_tok),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_char_o     (out_char_o),
    .event_kind_o   (event_kind_o),
    .tuple_begins_o (tuple_begins_o),
    .dropped_o      (dropped_o)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/avt_checker.sv =====
// Port-level checks for the tokenizer, bound to the top level.
`default_nettype none
module avt_checker
  import avt_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [ByteW-1:0]  out_char_o,
  input logic [KindW-1:0]  event_kind_o,
  input logic              tuple_begins_o,
  input logic              dropped_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_char_o)
      && $stable(event_kind_o))
    else $error("result changed while stalled");

  a_end_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o == EV_END |-> out_char_o == CH_NL)
    else $error("line end on a byte other than newline");

  a_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o == EV_END |-> !tuple_begins_o && !dropped_o)
    else $error("line end flagged as opener or drop");

  a_drop_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dropped_o |-> event_kind_o == EV_ATTR || event_kind_o == EV_VALUE)
    else $error("drop on a non-character event");

  a_begin_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tuple_begins_o |-> event_kind_o == EV_ATTR || event_kind_o == EV_SKIP)
    else $error("tuple opened by a value or line end");

endmodule

bind attr_value_tuple_tokenizer avt_checker u_avt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .out_char_o     (out_char_o),
  .event_kind_o   (event_kind_o),
  .tuple_begins_o (tuple_begins_o),
  .dropped_o      (dropped_o)
);
`default_nettype wire
